// ===== src/msob_pkg.sv =====
package msob_pkg;

  localparam int unsigned SCREEN_CELLS_DEF = 2048;
  localparam logic [7:0]  ROW_STRIDE_RST   = 8'd80;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_START  = 2'd2,
    OP_BITMAP = 2'd3
  } op_t;

  // data: cell code for a write, bitmap byte for a bitmap beat
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [6:0] col;
    logic [6:0] yq;
    logic [7:0] width;
    logic [7:0] height;
  } cmd_t;

  // 0x20..0x3F -> 0..31, 0x60..0x7F -> 32..63, anything else empty
  function automatic logic [5:0] code_to_mask(input logic [7:0] code);
    logic [5:0] m;
    case (code[7:5])
      3'b001:  m = {1'b0, code[4:0]};
      3'b011:  m = {1'b1, code[4:0]};
      default: m = 6'd0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] mask_to_code(input logic [5:0] m);
    return {1'b0, m[5], 1'b1, m[4:0]};
  endfunction

endpackage

// ===== src/msob_front.sv =====
module msob_front #(
  parameter int unsigned SCREEN_CELLS = msob_pkg::SCREEN_CELLS_DEF,
  localparam int unsigned AW = $clog2(SCREEN_CELLS)
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              q_ready,
  output logic              q_push,
  output msob_pkg::cmd_t    q_cmd,
  output logic [AW-1:0]     q_addr
);
  import msob_pkg::*;

  localparam int unsigned RW = 20;
  localparam logic [15:0] DIV3_RECIP = 16'd171;

  logic [15:0] y_mul;

  function automatic logic [AW-1:0] wrap_addr(input logic [10:0] a);
    logic [RW-1:0] v;
    v = RW'(a);
    for (int j = 3; j >= 0; j--) begin
      if (v >= (RW'(SCREEN_CELLS) << j)) v = v - (RW'(SCREEN_CELLS) << j);
    end
    return v[AW-1:0];
  endfunction

  assign y_mul     = 16'(in_tdata[34:27]) * DIV3_RECIP;
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;
  assign q_addr    = wrap_addr(in_tdata[10:0]);

  always_comb begin
    q_cmd.op     = op_t'(in_tuser);
    q_cmd.data   = (op_t'(in_tuser) == OP_WRITE) ? in_tdata[18:11] : in_tdata[58:51];
    q_cmd.col    = in_tdata[26:20];
    q_cmd.yq     = y_mul[15:9];
    q_cmd.width  = in_tdata[42:35];
    q_cmd.height = in_tdata[50:43];
  end

endmodule

// ===== src/msob_queue.sv =====
module msob_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign ready   = (count_r != 2'd2);
  assign valid   = (count_r != 2'd0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== src/msob_back.sv =====
module msob_back #(
  parameter int unsigned SCREEN_CELLS = msob_pkg::SCREEN_CELLS_DEF,
  localparam int unsigned AW = $clog2(SCREEN_CELLS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           q_valid,
  input  msob_pkg::cmd_t q_cmd,
  input  logic [AW-1:0]  q_addr,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata
);
  import msob_pkg::*;

  localparam int unsigned PW = 23;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD_OUT, S_RED, S_CELL, S_CELL_WR, S_STEP
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    stride_r, stride_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [7:0]    width_r, width_nxt;
  logic [7:0]    height_r, height_nxt;
  logic [7:0]    prc_r, prc_nxt;
  logic [4:0]    bir_r, bir_nxt;
  logic [1:0]    rib_r, rib_nxt;
  logic [1:0]    cc_r, cc_nxt;
  logic [14:0]   prod_r, prod_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  logic [7:0]    screen_mem_r [SCREEN_CELLS];
  logic [7:0]    rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [8:0]    wsum;
  logic [5:0]    rowbytes;
  logic [5:0]    bir_inc;
  logic          sprite_done;
  logic [7:0]    p0, p1;
  logic [2:0]    lsh, rsh;
  logic [5:0]    lbit, rbit, cell_mask;
  logic [AW:0]   cell_sum, band_sum;
  logic [AW-1:0] cell_addr, band_next;

  function automatic logic [AW-1:0] reduce_prod(input logic [14:0] p);
    logic [PW-1:0] v;
    v = PW'(p);
    for (int j = 6; j >= 0; j--) begin
      if (v >= (PW'(SCREEN_CELLS) << j)) v = v - (PW'(SCREEN_CELLS) << j);
    end
    return v[AW-1:0];
  endfunction

  assign wsum        = {1'b0, width_r} + 9'd7;
  assign rowbytes    = wsum[8:3];
  assign bir_inc     = {1'b0, bir_r} + 6'd1;
  assign sprite_done = (width_r == 8'd0) || (prc_r >= height_r);

  assign p0   = {bir_r, cc_r, 1'b0};
  assign p1   = {bir_r, cc_r, 1'b1};
  assign lsh  = 3'd7 - {cc_r, 1'b0};
  assign rsh  = 3'd6 - {cc_r, 1'b0};
  assign lbit = 6'b000001 << {rib_r, 1'b0};
  assign rbit = 6'b000010 << {rib_r, 1'b0};
  assign cell_mask = (((p0 < width_r) && cmd_r.data[lsh]) ? lbit : 6'd0) |
                     (((p1 < width_r) && cmd_r.data[rsh]) ? rbit : 6'd0);

  assign cell_sum  = (AW+1)'(base_r) + (AW+1)'(col_r) + (AW+1)'({bir_r, cc_r});
  assign cell_addr = (cell_sum >= (AW+1)'(SCREEN_CELLS)) ?
                     AW'(cell_sum - (AW+1)'(SCREEN_CELLS)) : AW'(cell_sum);
  assign band_sum  = (AW+1)'(base_r) + (AW+1)'(stride_r);
  assign band_next = (band_sum >= (AW+1)'(SCREEN_CELLS)) ?
                     AW'(band_sum - (AW+1)'(SCREEN_CELLS)) : AW'(band_sum);

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign mem_addr  = (state_r == S_EXEC) ? addr_r : cell_addr;
  assign mem_wdata = (state_r == S_EXEC) ? cmd_r.data :
                     mask_to_code(code_to_mask(rd_data_r) | cell_mask);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    stride_nxt    = cfg_we ? cfg_wdata : stride_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    prc_nxt       = prc_r;
    bir_nxt       = bir_r;
    rib_nxt       = rib_r;
    cc_nxt        = cc_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt   = q_cmd;
          addr_nxt  = q_addr;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r.op)
          OP_WRITE: begin
            mem_we    = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_READ: begin
            mem_re    = 1'b1;
            state_nxt = S_RD_OUT;
          end
          OP_START: begin
            prod_nxt   = 15'(cmd_r.yq) * 15'(stride_r);
            col_nxt    = cmd_r.col;
            width_nxt  = cmd_r.width;
            height_nxt = cmd_r.height;
            prc_nxt    = 8'd0;
            bir_nxt    = 5'd0;
            rib_nxt    = 2'd0;
            state_nxt  = S_RED;
          end
          OP_BITMAP: begin
            cc_nxt    = 2'd0;
            state_nxt = sprite_done ? S_IDLE : S_CELL;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          state_nxt     = S_IDLE;
        end
      end
      S_RED: begin
        base_nxt  = reduce_prod(prod_r);
        state_nxt = S_IDLE;
      end
      S_CELL: begin
        if (cell_mask != 6'd0) begin
          mem_re    = 1'b1;
          state_nxt = S_CELL_WR;
        end else if (cc_r == 2'd3) begin
          state_nxt = S_STEP;
        end else begin
          cc_nxt = cc_r + 2'd1;
        end
      end
      S_CELL_WR: begin
        mem_we = 1'b1;
        if (cc_r == 2'd3) begin
          state_nxt = S_STEP;
        end else begin
          cc_nxt    = cc_r + 2'd1;
          state_nxt = S_CELL;
        end
      end
      S_STEP: begin
        if (bir_inc >= rowbytes) begin
          bir_nxt = 5'd0;
          prc_nxt = prc_r + 8'd1;
          if (rib_r == 2'd2) begin
            rib_nxt  = 2'd0;
            base_nxt = band_next;
          end else begin
            rib_nxt = rib_r + 2'd1;
          end
        end else begin
          bir_nxt = bir_inc[4:0];
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stride_r    <= ROW_STRIDE_RST;
      col_r       <= 7'd0;
      base_r      <= '0;
      width_r     <= 8'd0;
      height_r    <= 8'd0;
      prc_r       <= 8'd0;
      bir_r       <= 5'd0;
      rib_r       <= 2'd0;
      cc_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stride_r    <= stride_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      prc_r       <= prc_nxt;
      bir_r       <= bir_nxt;
      rib_r       <= rib_nxt;
      cc_r        <= cc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen_mem_r[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= screen_mem_r[mem_addr];
  end

endmodule

// ===== src/mosaic_sprite_or_blit_core.sv =====
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tuser action, in_tdata cell and sprite fields
// out     | out | out_tvalid/tready  | out_tdata read_data
// cfg     | in  | cfg_we             | cfg_wdata row_stride
//
// In the back end a write uses S_EXEC, a read S_EXEC and S_RD_OUT, a start
// S_EXEC and S_RED. A bitmap byte for a sprite that is done stops in S_EXEC;
// else the single-port screen store makes it test each of the four cells in
// turn in S_CELL, write back in S_CELL_WR a cell that gets pixels, then S_STEP.
// The two-entry queue lets beats in while the back end works.
// rst_n is synchronous; the screen store keeps its contents through reset.
// A stalled out beat holds; a read then waits in the back end and the queue fills.
module mosaic_sprite_or_blit_core #(
  parameter int unsigned SCREEN_CELLS = msob_pkg::SCREEN_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_address[10:0], cell_code[18:11], x_pixel[26:19], y_pixel[34:27],
  // sprite_width[42:35], sprite_height[50:43], bitmap_byte[58:51], zero above
  input  logic [63:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import msob_pkg::*;

  localparam int unsigned AW = $clog2(SCREEN_CELLS);
  localparam int unsigned QW = AW + $bits(cmd_t);

  logic          fq_ready, fq_push;
  cmd_t          f_cmd, b_cmd;
  logic [AW-1:0] f_addr, b_addr;
  logic          qb_valid, qb_pop;
  logic [QW-1:0] qb_data;

  assign b_cmd  = cmd_t'(qb_data[$bits(cmd_t)-1:0]);
  assign b_addr = qb_data[QW-1:$bits(cmd_t)];

  msob_front #(.SCREEN_CELLS(SCREEN_CELLS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (fq_ready),
    .q_push    (fq_push),
    .q_cmd     (f_cmd),
    .q_addr    (f_addr)
  );

  msob_queue #(.DW(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({f_addr, f_cmd}),
    .ready (fq_ready),
    .pop   (qb_pop),
    .valid (qb_valid),
    .rdata (qb_data)
  );

  msob_back #(.SCREEN_CELLS(SCREEN_CELLS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (qb_valid),
    .q_cmd      (b_cmd),
    .q_addr     (b_addr),
    .q_pop      (qb_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/msob_checker.sv =====
module msob_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat dropped or changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left a result pending or the queue full");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("in_tready fell without an accepted beat");

endmodule

bind mosaic_sprite_or_blit_core msob_checker u_msob_checker (.*);
